### sv/tfn_pkg.sv
// tfn_pkg: shared constants and types for the triangle face normal pipeline
// no dependencies
`default_nettype none

package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // the largest block-normalised magnitude sits in [2^29, 2^30) unless all are zero
  localparam int NORM_BITS  = 30;
  localparam int NORM_MSB   = 29;
  localparam int SHIFT_BITS = 6;

  // sum of squares and integer square root
  localparam int SUM_BITS   = 64;
  localparam int ROOT_BITS  = 31;
  localparam int ROOT_STEPS = 31;

  typedef logic [NORM_BITS-1:0] nmag_t;

  typedef struct packed {
    nmag_t [2:0] mag;
    logic  [2:0] neg;
    logic        zero;
  } vec_t;

endpackage

`default_nettype wire

### sv/triangle_face_normal.sv
// triangle_face_normal: unit normal of (a-b) x (a-c), one triangle per transfer
// depends on tfn_pkg
//
//  channel  dir  signals                      content
//  s_*      in   tvalid tready tdata          nine vertex coordinates
//  m_*      out  tvalid tready tdata tuser    normal components, degenerate flag
//
//  one triangle per cycle while the output is not stalled
//  the pipeline holds the 31-step square root and the one-bit-per-stage dividers
//  every stage advances together when the output register is empty or taken
//  rst clears the valid bits only; no clearing pass
`default_nettype none

module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  wire                                                 clk,
  input  wire                                                 rst,
  input  wire                                                 s_tvalid,
  output logic                                                s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  wire  [((9*COORD_WIDTH+7)/8)*8-1:0]                  s_tdata,
  output logic                                                m_tvalid,
  input  wire                                                 m_tready,
  // nx, ny, nz
  output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0]         m_tdata,
  // degenerate
  output logic                                                m_tuser
);

  localparam int CW        = COORD_WIDTH;
  localparam int F         = NORMAL_FRAC_BITS;
  localparam int DW        = (CW > 30 ? 30 : CW) + 1;
  localparam int PRE       = CW > 30 ? CW - 30 : 0;
  localparam int PW        = 2 * DW;
  localparam int KW        = PW + 1;
  localparam int MW        = PW;
  localparam int PIDX_W    = $clog2(MW);
  localparam int OW        = F + 2;
  localparam int OUT_W     = ((3*OW+7)/8)*8;
  localparam int NW        = F + NORM_BITS + 1;
  localparam int DIV_STEPS = F + 1;
  localparam int NST       = 8 + ROOT_STEPS + 1 + DIV_STEPS + 1;
  localparam int ST_PREP   = 8 + ROOT_STEPS;

  logic           en;
  logic [NST-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // edge differences
  logic        [CW-1:0] crd     [9];
  logic signed [DW-1:0] ed_next [6];
  logic signed [DW-1:0] ed      [6];

  genvar g;
  for (g = 0; g < 9; g++) begin : g_crd
    assign crd[g] = s_tdata[g*CW +: CW];
  end

  for (g = 0; g < 6; g++) begin : g_edge
    logic [CW:0]   df;
    logic [CW:0]   dm;
    logic [CW:0]   ds;
    logic [DW-1:0] dt;
    assign df         = {crd[g%3][CW-1], crd[g%3]} - {crd[g+3][CW-1], crd[g+3]};
    assign dm         = df[CW] ? (~df + 1'b1) : df;
    assign ds         = dm >> PRE;
    assign dt         = ds[DW-1:0];
    assign ed_next[g] = df[CW] ? (~dt + 1'b1) : dt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ed <= ed_next;
    end
  end

  // products
  logic signed [PW-1:0] prod [6];

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= ed[1] * ed[5];
      prod[1] <= ed[2] * ed[4];
      prod[2] <= ed[2] * ed[3];
      prod[3] <= ed[0] * ed[5];
      prod[4] <= ed[0] * ed[4];
      prod[5] <= ed[1] * ed[3];
    end
  end

  // cross product
  logic signed [KW-1:0] kv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      kv[0] <= KW'(prod[0]) - KW'(prod[1]);
      kv[1] <= KW'(prod[2]) - KW'(prod[3]);
      kv[2] <= KW'(prod[4]) - KW'(prod[5]);
    end
  end

  // magnitudes and largest magnitude
  logic [KW-1:0] ka [3];
  logic [MW-1:0] mg_next [3];
  logic [MW-1:0] mx01;
  logic [MW-1:0] mx_next;
  logic [MW-1:0] mg4 [3];
  logic [2:0]    ng4;
  logic [MW-1:0] mx;

  for (g = 0; g < 3; g++) begin : g_abs
    assign ka[g]      = kv[g][KW-1] ? (~kv[g] + 1'b1) : kv[g];
    assign mg_next[g] = ka[g][MW-1:0];
  end

  assign mx01    = (mg_next[0] > mg_next[1]) ? mg_next[0] : mg_next[1];
  assign mx_next = (mx01 > mg_next[2]) ? mx01 : mg_next[2];

  always_ff @(posedge clk) begin
    if (en) begin
      mg4 <= mg_next;
      ng4 <= {kv[2][KW-1], kv[1][KW-1], kv[0][KW-1]};
      mx  <= mx_next;
    end
  end

  // leading one and shift amount
  logic [PIDX_W-1:0]     pidx;
  logic [SHIFT_BITS-1:0] pos;
  logic [MW-1:0]         mg5 [3];
  logic [2:0]            ng5;
  logic                  zr5;
  logic                  dn5;
  logic [SHIFT_BITS-1:0] amt5;

  always_comb begin
    pidx = '0;
    for (int i = 0; i < MW; i++) begin
      if (mx[i]) begin
        pidx = PIDX_W'(i);
      end
    end
  end

  assign pos = SHIFT_BITS'(pidx);

  always_ff @(posedge clk) begin
    if (en) begin
      mg5  <= mg4;
      ng5  <= ng4;
      zr5  <= (mx == '0);
      dn5  <= (pos >= SHIFT_BITS'(NORM_MSB));
      amt5 <= (pos >= SHIFT_BITS'(NORM_MSB)) ? pos - SHIFT_BITS'(NORM_MSB)
                                             : SHIFT_BITS'(NORM_MSB) - pos;
    end
  end

  // block normalisation
  vec_t v6_next;
  vec_t v6;

  for (g = 0; g < 3; g++) begin : g_norm
    logic [MW+NORM_BITS-1:0] wide;
    logic [MW+NORM_BITS-1:0] shd;
    assign wide           = {{NORM_BITS{1'b0}}, mg5[g]};
    assign shd            = dn5 ? (wide >> amt5) : (wide << amt5);
    assign v6_next.mag[g] = shd[NORM_BITS-1:0];
  end

  assign v6_next.neg  = ng5;
  assign v6_next.zero = zr5;

  always_ff @(posedge clk) begin
    if (en) begin
      v6 <= v6_next;
    end
  end

  // squares
  logic [2*NORM_BITS-1:0] sq [3];
  vec_t                   v7;

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= v6.mag[0] * v6.mag[0];
      sq[1] <= v6.mag[1] * v6.mag[1];
      sq[2] <= v6.mag[2] * v6.mag[2];
      v7    <= v6;
    end
  end

  // integer square root, one result bit per stage
  logic [SUM_BITS-1:0] rx [ROOT_STEPS+1];
  logic [SUM_BITS-1:0] rr [ROOT_STEPS+1];
  vec_t                rv [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);
      rr[0] <= '0;
      rv[0] <= v7;
    end
  end

  for (g = 0; g < ROOT_STEPS; g++) begin : g_root
    localparam logic [SUM_BITS-1:0] BITV = SUM_BITS'(1) << (2*(ROOT_STEPS-1-g));
    logic [SUM_BITS-1:0] trial;
    logic                ge;
    assign trial = rr[g] + BITV;
    assign ge    = rx[g] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rx[g+1] <= ge ? rx[g] - trial : rx[g];
        rr[g+1] <= ge ? (rr[g] >> 1) + BITV : rr[g] >> 1;
        rv[g+1] <= rv[g];
      end
    end
  end

  // dividers: (mag * 2^F + r/2) / r, one quotient bit per stage
  logic [ROOT_BITS-1:0] root;
  logic [NW-1:0]        num_next [3];

  logic [ROOT_BITS-1:0] dr   [DIV_STEPS+1];
  vec_t                 dvv  [DIV_STEPS+1];
  logic [NW-1:0]        num  [DIV_STEPS+1][3];
  logic [ROOT_BITS-1:0] rem  [DIV_STEPS+1][3];
  logic [F:0]           quo  [DIV_STEPS+1][3];

  assign root = rr[ROOT_STEPS][ROOT_BITS-1:0];

  for (g = 0; g < 3; g++) begin : g_prep
    logic [NW-1:0] nsh;
    assign num_next[g] = (NW'(rv[ROOT_STEPS].mag[g]) << F) + NW'(root >> 1);
    assign nsh         = num_next[g] >> (F + 1);
    always_ff @(posedge clk) begin
      if (en) begin
        num[0][g] <= num_next[g];
        rem[0][g] <= nsh[ROOT_BITS-1:0];
        quo[0][g] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]  <= root;
      dvv[0] <= rv[ROOT_STEPS];
    end
  end

  for (g = 0; g < DIV_STEPS; g++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [ROOT_BITS:0] sh;
      logic [ROOT_BITS:0] df;
      logic               ge;
      assign sh = {rem[g][l], num[g][l][F-g]};
      assign ge = sh >= {1'b0, dr[g]};
      assign df = sh - {1'b0, dr[g]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g+1][l] <= ge ? df[ROOT_BITS-1:0] : sh[ROOT_BITS-1:0];
          quo[g+1][l] <= {quo[g][l][F-1:0], ge};
          num[g+1][l] <= num[g][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr[g+1]  <= dr[g];
        dvv[g+1] <= dvv[g];
      end
    end
  end

  // sign and degenerate case
  logic [OW-1:0] nv_next [3];
  logic [OW-1:0] nv      [3];
  logic          dgn;

  for (g = 0; g < 3; g++) begin : g_out
    logic [OW-1:0] qe;
    assign qe         = OW'(quo[DIV_STEPS][g]);
    assign nv_next[g] = dvv[DIV_STEPS].zero  ? '0 :
                        dvv[DIV_STEPS].neg[g] ? (~qe + 1'b1) : qe;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv  <= nv_next;
      dgn <= dvv[DIV_STEPS].zero;
    end
  end

  assign m_tdata = OUT_W'({nv[2], nv[1], nv[0]});
  assign m_tuser = dgn;

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result carries a non-zero normal");

  a_normal_nonzero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (nv[0] != '0) || (nv[1] != '0) || (nv[2] != '0))
    else $error("non-degenerate result has a zero normal");

  a_root_range : assert property (@(posedge clk) disable iff (rst)
    vld[ST_PREP] && !dvv[0].zero |-> dr[0][ROOT_BITS-1:ROOT_BITS-2] != 2'b00)
    else $error("square root below normalised range");

  a_rem_below_root : assert property (@(posedge clk) disable iff (rst)
    vld[ST_PREP] && !dvv[0].zero |->
      (rem[0][0] < dr[0]) && (rem[0][1] < dr[0]) && (rem[0][2] < dr[0]))
    else $error("divider start remainder not below divisor");

  a_quo_bound : assert property (@(posedge clk) disable iff (rst)
    vld[NST-2] && !dvv[DIV_STEPS].zero |->
      (quo[DIV_STEPS][0] <= (F+1)'(1) << F) && (quo[DIV_STEPS][1] <= (F+1)'(1) << F) &&
      (quo[DIV_STEPS][2] <= (F+1)'(1) << F))
    else $error("normal component exceeds unit length");

endmodule

`default_nettype wire
